[rtl/atf_pkg.sv]
// ----------------------------------------------------------------------------
// atf_pkg: shared types and constants of the audio transition fader
// Op and register codes, fader phases, controller states and the command
// word that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package atf_pkg;

    localparam int MAX_CHANNELS     = 8;
    localparam int SAMPLE_BITS_DEF  = 24;
    localparam int COUNT_BITS_DEF   = 16;
    localparam int CC_BITS          = 4;
    localparam int GEN_BITS         = 32;
    localparam int CFG_BITS         = 32;
    localparam int CFG_IDX_BITS     = 2;
    localparam int OP_BITS          = 2;
    localparam int PHASE_BITS       = 3;

    typedef logic [OP_BITS-1:0] op_t;
    localparam op_t OP_FRAME = 2'd0;
    localparam op_t OP_RESET = 2'd1;
    localparam op_t OP_BEGIN = 2'd2;

    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_CHANNEL_COUNT  = 2'd0;
    localparam cfg_idx_t REG_SILENCE_FRAMES = 2'd1;
    localparam cfg_idx_t REG_FADE_FRAMES    = 2'd2;
    localparam cfg_idx_t REG_INITIAL_GEN    = 2'd3;

    typedef enum logic [PHASE_BITS-1:0] {
        PH_STEADY   = 3'd0,
        PH_FADE_OUT = 3'd1,
        PH_SILENT   = 3'd2,
        PH_AWAIT    = 3'd3,
        PH_FADE_IN  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_ZERO,
        MODE_ORIGIN,
        MODE_INPUT
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_WRITE
    } ctrl_state_t;

    typedef struct packed {
        logic                    load;
        logic                    clear;
        logic                    copy;
        logic                    mul;
        logic                    div_step;
        logic                    write;
        mode_t                   mode;
        logic [MAX_CHANNELS-1:0] active;
    } dp_cmd_t;

endpackage

[rtl/atf_datapath.sv]
// ----------------------------------------------------------------------------
// atf_datapath: sample lanes of the audio transition fader
// One lane per channel: input and origin registers, a multiplier and a
// restoring divider that produce one quotient bit per step, output register.
// ----------------------------------------------------------------------------
module atf_datapath #(
    parameter int SAMPLE_BITS = atf_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = atf_pkg::COUNT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  atf_pkg::dp_cmd_t              cmd,
    input  logic [COUNT_BITS-1:0]         num,
    input  logic [COUNT_BITS-1:0]         den,
    input  logic signed [SAMPLE_BITS-1:0] sample_in  [atf_pkg::MAX_CHANNELS],
    output logic signed [SAMPLE_BITS-1:0] sample_out [atf_pkg::MAX_CHANNELS]
);
    import atf_pkg::*;

    localparam int DIV_BITS  = SAMPLE_BITS + COUNT_BITS;
    localparam int PROD_BITS = DIV_BITS + 1;

    for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
        logic signed [SAMPLE_BITS-1:0] in_reg;
        logic signed [SAMPLE_BITS-1:0] origin_reg;
        logic signed [SAMPLE_BITS-1:0] last_reg;
        logic signed [SAMPLE_BITS-1:0] out_reg;
        logic [DIV_BITS-1:0]           quo_reg;
        logic [COUNT_BITS-1:0]         rem_reg;
        logic                          sign_reg;

        logic signed [SAMPLE_BITS-1:0] src;
        logic signed [PROD_BITS-1:0]   prod;
        logic [PROD_BITS-1:0]          mag;
        logic [COUNT_BITS:0]           trial;
        logic [COUNT_BITS:0]           diff;
        logic [SAMPLE_BITS-1:0]        quo;
        logic signed [SAMPLE_BITS-1:0] res;
        logic signed [SAMPLE_BITS-1:0] sel;

        always_comb begin
            src   = (cmd.mode == MODE_ORIGIN) ? origin_reg : in_reg;
            prod  = src * $signed({1'b0, num});
            mag   = prod[PROD_BITS-1] ? PROD_BITS'(-prod) : PROD_BITS'(prod);
            trial = {rem_reg, quo_reg[DIV_BITS-1]};
            diff  = trial - {1'b0, den};
            quo   = quo_reg[SAMPLE_BITS-1:0];
            res   = sign_reg ? -$signed(quo) : $signed(quo);
            if (!cmd.active[c]) begin
                sel = in_reg;
            end else begin
                case (cmd.mode)
                    MODE_PASS: sel = in_reg;
                    MODE_ZERO: sel = '0;
                    default:   sel = res;
                endcase
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                origin_reg <= '0;
                last_reg   <= '0;
            end else if (cmd.clear) begin
                origin_reg <= '0;
                last_reg   <= '0;
            end else begin
                if (cmd.copy) begin
                    origin_reg <= last_reg;
                end
                if (cmd.write && cmd.active[c]) begin
                    last_reg <= sel;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (cmd.load) begin
                in_reg <= sample_in[c];
            end
            if (cmd.mul) begin
                quo_reg  <= mag[DIV_BITS-1:0];
                rem_reg  <= '0;
                sign_reg <= prod[PROD_BITS-1];
            end else if (cmd.div_step) begin
                if (trial >= {1'b0, den}) begin
                    rem_reg <= diff[COUNT_BITS-1:0];
                    quo_reg <= {quo_reg[DIV_BITS-2:0], 1'b1};
                end else begin
                    rem_reg <= trial[COUNT_BITS-1:0];
                    quo_reg <= {quo_reg[DIV_BITS-2:0], 1'b0};
                end
            end
            if (cmd.write) begin
                out_reg <= sel;
            end
        end

        assign sample_out[c] = out_reg;
    end

endmodule

[rtl/atf_ctrl.sv]
// ----------------------------------------------------------------------------
// atf_ctrl: controller of the audio transition fader
// Holds configuration and fader phase state, resolves the phase that handles
// each frame and sequences multiply, divide and output write.
// ----------------------------------------------------------------------------
module atf_ctrl #(
    parameter int SAMPLE_BITS = atf_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = atf_pkg::COUNT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [atf_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [atf_pkg::CFG_BITS-1:0]  cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [atf_pkg::OP_BITS-1:0]   s_op,
    input  logic                          s_available,
    input  logic [atf_pkg::GEN_BITS-1:0]  s_generation,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_adjusted,
    output logic [atf_pkg::PHASE_BITS-1:0] m_phase_now,
    output atf_pkg::dp_cmd_t              cmd,
    output logic [COUNT_BITS-1:0]         num,
    output logic [COUNT_BITS-1:0]         den
);
    import atf_pkg::*;

    localparam int DIV_BITS = SAMPLE_BITS + COUNT_BITS;
    localparam int CNT_BITS = $clog2(DIV_BITS);

    ctrl_state_t             state_reg, state_next;
    phase_t                  phase_reg, phase_next;
    logic [COUNT_BITS-1:0]   fl_reg, fl_next;
    logic [COUNT_BITS-1:0]   ps_reg, ps_next;
    logic [GEN_BITS-1:0]     seen_reg, seen_next;
    logic [CC_BITS-1:0]      cc_reg, cc_next;
    logic [COUNT_BITS-1:0]   sil_reg, sil_next;
    logic [COUNT_BITS-1:0]   fad_reg, fad_next;
    mode_t                   mode_reg, mode_next;
    logic [COUNT_BITS-1:0]   num_reg, num_next;
    logic [MAX_CHANNELS-1:0] act_reg, act_next;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic                    adj_reg, adj_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    m_adj_reg, m_adj_next;
    phase_t                  m_phase_reg, m_phase_next;

    phase_t                  bt_phase;
    logic [COUNT_BITS-1:0]   bt_fl;
    logic [COUNT_BITS-1:0]   bt_ps;
    phase_t                  rp, np;
    logic [COUNT_BITS-1:0]   rfl, rps, nfl, nps, fl_dec, fr_num;
    logic                    rcopy;
    mode_t                   fr_mode;
    logic [MAX_CHANNELS-1:0] act_mask;

    always_comb begin
        bt_phase = PH_AWAIT;
        bt_fl    = '0;
        bt_ps    = sil_reg;
        if (fad_reg != '0) begin
            bt_phase = PH_FADE_OUT;
            bt_fl    = fad_reg;
        end else if (sil_reg != '0) begin
            bt_phase = PH_SILENT;
            bt_fl    = sil_reg;
            bt_ps    = '0;
        end
    end

    always_comb begin
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            act_mask[c] = (32'(cc_reg) > c);
        end
    end

    // resolve the phase that handles this frame, then step it
    always_comb begin
        rp    = phase_reg;
        rfl   = fl_reg;
        rps   = ps_reg;
        rcopy = 1'b0;
        if (s_generation != seen_reg) begin
            rp    = bt_phase;
            rfl   = bt_fl;
            rps   = bt_ps;
            rcopy = 1'b1;
        end
        for (int i = 0; i < 4; i++) begin
            case (rp)
                PH_STEADY, PH_FADE_IN: begin
                    if (!s_available) begin
                        rp    = bt_phase;
                        rfl   = bt_fl;
                        rps   = bt_ps;
                        rcopy = 1'b1;
                    end
                end
                PH_AWAIT: begin
                    if (s_available) begin
                        if (fad_reg == '0) begin
                            rp = PH_STEADY;
                        end else begin
                            rp  = PH_FADE_IN;
                            rfl = fad_reg;
                        end
                    end
                end
                PH_FADE_OUT, PH_SILENT: ;
                default: rp = PH_STEADY;
            endcase
        end

        np      = rp;
        nfl     = rfl;
        nps     = rps;
        fr_mode = MODE_PASS;
        fr_num  = '0;
        fl_dec  = (rfl == '0) ? '0 : rfl - 1'b1;
        case (rp)
            PH_FADE_OUT: begin
                fr_num  = (fl_dec > fad_reg) ? fad_reg : fl_dec;
                fr_mode = (fad_reg == '0) ? MODE_ZERO : MODE_ORIGIN;
                nfl     = fl_dec;
                if (fl_dec == '0) begin
                    if (rps == '0) begin
                        np = PH_AWAIT;
                    end else begin
                        np  = PH_SILENT;
                        nfl = rps;
                        nps = '0;
                    end
                end
            end
            PH_SILENT: begin
                fr_mode = MODE_ZERO;
                if (s_available) begin
                    nfl = fl_dec;
                    if (fl_dec == '0) begin
                        np = PH_AWAIT;
                    end
                end
            end
            PH_AWAIT: begin
                fr_mode = MODE_ZERO;
            end
            PH_FADE_IN: begin
                fr_mode = (fad_reg == '0) ? MODE_ZERO : MODE_INPUT;
                if (rfl > fad_reg) begin
                    fr_num = '0;
                end else if (rfl == '0) begin
                    fr_num = fad_reg;
                end else begin
                    fr_num = fad_reg - rfl + 1'b1;
                end
                nfl = fl_dec;
                if (fl_dec == '0) begin
                    np = PH_STEADY;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        fl_next      = fl_reg;
        ps_next      = ps_reg;
        seen_next    = seen_reg;
        cc_next      = cc_reg;
        sil_next     = sil_reg;
        fad_next     = fad_reg;
        mode_next    = mode_reg;
        num_next     = num_reg;
        act_next     = act_reg;
        cnt_next     = cnt_reg;
        adj_next     = adj_reg;
        m_adj_next   = m_adj_reg;
        m_phase_next = m_phase_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.mode     = mode_reg;
        cmd.active   = act_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_CHANNEL_COUNT:  cc_next   = cfg_wdata[CC_BITS-1:0];
                REG_SILENCE_FRAMES: sil_next  = cfg_wdata[COUNT_BITS-1:0];
                REG_FADE_FRAMES:    fad_next  = cfg_wdata[COUNT_BITS-1:0];
                REG_INITIAL_GEN:    seen_next = cfg_wdata[GEN_BITS-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_op)
                        OP_FRAME: begin
                            seen_next  = s_generation;
                            phase_next = np;
                            fl_next    = nfl;
                            ps_next    = nps;
                            mode_next  = fr_mode;
                            num_next   = fr_num;
                            act_next   = act_mask;
                            adj_next   = (fr_mode != MODE_PASS);
                            cmd.load   = 1'b1;
                            cmd.copy   = rcopy;
                            if (fr_mode == MODE_ORIGIN || fr_mode == MODE_INPUT) begin
                                state_next = ST_MUL;
                            end else begin
                                state_next = ST_WRITE;
                            end
                        end
                        OP_RESET: begin
                            cmd.clear = 1'b1;
                            ps_next   = '0;
                            if (sil_reg == '0) begin
                                phase_next = PH_AWAIT;
                                fl_next    = '0;
                            end else begin
                                phase_next = PH_SILENT;
                                fl_next    = sil_reg;
                            end
                        end
                        OP_BEGIN: begin
                            cmd.copy   = 1'b1;
                            phase_next = bt_phase;
                            fl_next    = bt_fl;
                            ps_next    = bt_ps;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                cnt_next   = CNT_BITS'(DIV_BITS - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_WRITE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_WRITE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.write    = 1'b1;
                    m_valid_next = 1'b1;
                    m_adj_next   = adj_reg;
                    m_phase_next = phase_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_STEADY;
            fl_reg      <= '0;
            ps_reg      <= '0;
            seen_reg    <= '0;
            cc_reg      <= CC_BITS'(2);
            sil_reg     <= '0;
            fad_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            fl_reg      <= fl_next;
            ps_reg      <= ps_next;
            seen_reg    <= seen_next;
            cc_reg      <= cc_next;
            sil_reg     <= sil_next;
            fad_reg     <= fad_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        num_reg     <= num_next;
        act_reg     <= act_next;
        cnt_reg     <= cnt_next;
        adj_reg     <= adj_next;
        m_adj_reg   <= m_adj_next;
        m_phase_reg <= m_phase_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_adjusted  = m_adj_reg;
    assign m_phase_now = m_phase_reg;
    assign num         = num_reg;
    assign den         = fad_reg;

    a_write_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write |=> m_valid_reg)
        else $error("result register not loaded after write");

    a_await_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_AWAIT) |-> (fl_reg == '0))
        else $error("frame count nonzero while awaiting audio");

    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_op == OP_FRAME) |=>
            (state_reg == ST_MUL || state_reg == ST_WRITE))
        else $error("accepted frame not started");

    a_mul_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |=> (state_reg == ST_DIV && cnt_reg == CNT_BITS'(DIV_BITS - 1)))
        else $error("divide not started after multiply");

endmodule

[rtl/audio_transition_fader.sv]
// ----------------------------------------------------------------------------
// audio_transition_fader: fade, silence and resume shaping of audio frames
// Ramped frames pass the multiply state, the one-bit-per-step restoring
// divider and the write state; other frames go straight to the write state;
// ops other than frame give no result. Throughput: ops every cycle while
// idle, a frame only once the last is written out; next item accepted while
// a result waits. Reset: synchronous active-low aresetn; phase steady,
// channel count 2, other counts 0, origin and last samples 0.
// ----------------------------------------------------------------------------
module audio_transition_fader #(
    parameter int SAMPLE_BITS = atf_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = atf_pkg::COUNT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [atf_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [atf_pkg::CFG_BITS-1:0]     cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [atf_pkg::OP_BITS-1:0]      s_op,
    input  logic                             s_available,
    input  logic [atf_pkg::GEN_BITS-1:0]     s_generation,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_in_0,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_in_1,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_in_2,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_in_3,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_in_4,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_in_5,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_in_6,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_in_7,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [SAMPLE_BITS-1:0]    m_sample_out_0,
    output logic signed [SAMPLE_BITS-1:0]    m_sample_out_1,
    output logic signed [SAMPLE_BITS-1:0]    m_sample_out_2,
    output logic signed [SAMPLE_BITS-1:0]    m_sample_out_3,
    output logic signed [SAMPLE_BITS-1:0]    m_sample_out_4,
    output logic signed [SAMPLE_BITS-1:0]    m_sample_out_5,
    output logic signed [SAMPLE_BITS-1:0]    m_sample_out_6,
    output logic signed [SAMPLE_BITS-1:0]    m_sample_out_7,
    output logic                             m_adjusted,
    output logic [atf_pkg::PHASE_BITS-1:0]   m_phase_now
);
    import atf_pkg::*;

    dp_cmd_t                       cmd;
    logic [COUNT_BITS-1:0]         num;
    logic [COUNT_BITS-1:0]         den;
    logic signed [SAMPLE_BITS-1:0] sample_in  [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] sample_out [MAX_CHANNELS];

    assign sample_in[0] = s_sample_in_0;
    assign sample_in[1] = s_sample_in_1;
    assign sample_in[2] = s_sample_in_2;
    assign sample_in[3] = s_sample_in_3;
    assign sample_in[4] = s_sample_in_4;
    assign sample_in[5] = s_sample_in_5;
    assign sample_in[6] = s_sample_in_6;
    assign sample_in[7] = s_sample_in_7;

    assign m_sample_out_0 = sample_out[0];
    assign m_sample_out_1 = sample_out[1];
    assign m_sample_out_2 = sample_out[2];
    assign m_sample_out_3 = sample_out[3];
    assign m_sample_out_4 = sample_out[4];
    assign m_sample_out_5 = sample_out[5];
    assign m_sample_out_6 = sample_out[6];
    assign m_sample_out_7 = sample_out[7];

    atf_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_available  (s_available),
        .s_generation (s_generation),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_adjusted   (m_adjusted),
        .m_phase_now  (m_phase_now),
        .cmd          (cmd),
        .num          (num),
        .den          (den)
    );

    atf_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .num        (num),
        .den        (den),
        .sample_in  (sample_in),
        .sample_out (sample_out)
    );

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the audio transition fader
// Drives frames and control ops through the valid/ready input channel, works
// out each expected output frame with a local model of the fade, silence and
// resume phases, and compares every field of every output beat in order.
// ----------------------------------------------------------------------------
module tb_top;
    import atf_pkg::*;

    localparam int NCH = MAX_CHANNELS;
    localparam int SB = 24;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        op_t                op;
        logic               avail;
        logic [31:0]        gen;
        logic signed [SB-1:0] smp [NCH];
    } frame_t;

    typedef struct {
        logic signed [SB-1:0] smp [NCH];
        logic                 adj;
        logic [2:0]           ph;
    } shaped_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    cfg_idx_t cfg_index = REG_CHANNEL_COUNT;
    logic [31:0] cfg_wdata = 0;
    logic s_valid = 0;
    logic s_ready;
    op_t s_op = OP_FRAME;
    logic s_available = 0;
    logic [31:0] s_generation = 0;
    logic signed [SB-1:0] s_in [NCH];
    logic m_valid;
    logic m_ready = 0;
    logic signed [SB-1:0] m_out [NCH];
    logic m_adjusted;
    logic [2:0] m_phase_now;

    initial for (int i = 0; i < NCH; i++) s_in[i] = '0;

    audio_transition_fader u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_available(s_available), .s_generation(s_generation),
        .s_sample_in_0(s_in[0]), .s_sample_in_1(s_in[1]),
        .s_sample_in_2(s_in[2]), .s_sample_in_3(s_in[3]),
        .s_sample_in_4(s_in[4]), .s_sample_in_5(s_in[5]),
        .s_sample_in_6(s_in[6]), .s_sample_in_7(s_in[7]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_sample_out_0(m_out[0]), .m_sample_out_1(m_out[1]),
        .m_sample_out_2(m_out[2]), .m_sample_out_3(m_out[3]),
        .m_sample_out_4(m_out[4]), .m_sample_out_5(m_out[5]),
        .m_sample_out_6(m_out[6]), .m_sample_out_7(m_out[7]),
        .m_adjusted(m_adjusted), .m_phase_now(m_phase_now)
    );

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    // fader model state
    logic [3:0]  cc_reg = 2;
    logic [15:0] sil_reg = 0, fad_reg = 0;
    logic [31:0] seen_gen = 0;
    phase_t      fphase = PH_STEADY;
    logic [15:0] frames_left = 0, pending_sil = 0;
    logic signed [SB-1:0] last_out [NCH];
    logic signed [SB-1:0] origin [NCH];

    initial for (int i = 0; i < NCH; i++) begin
        last_out[i] = '0;
        origin[i] = '0;
    end

    frame_t  pending_q [$];
    shaped_t expect_q [$];
    int errors = 0, n_frames = 0, n_ctrl = 0, n_checked = 0;
    bit stim_done = 0, hold_send = 0;
    longint cycles = 0;

    function automatic logic signed [SB-1:0] ramp(logic signed [SB-1:0] s,
                                                  longint num, longint den);
        longint p;
        if (den == 0) return '0;
        if (num > den) num = den;
        p = longint'(s) * num;
        return SB'(p / den);
    endfunction

    task automatic start_transition();
        origin = last_out;
        pending_sil = sil_reg;
        if (fad_reg != 0) begin
            fphase = PH_FADE_OUT;
            frames_left = fad_reg;
        end else if (sil_reg != 0) begin
            fphase = PH_SILENT;
            frames_left = sil_reg;
            pending_sil = 0;
        end else begin
            fphase = PH_AWAIT;
            frames_left = 0;
        end
    endtask

    task automatic shape_frame(frame_t f);
        shaped_t r;
        int act;
        bit again;
        longint num;
        if (f.op == OP_RESET) begin
            for (int c = 0; c < NCH; c++) begin
                last_out[c] = '0;
                origin[c] = '0;
            end
            pending_sil = 0;
            if (sil_reg == 0) begin
                fphase = PH_AWAIT;
                frames_left = 0;
            end else begin
                fphase = PH_SILENT;
                frames_left = sil_reg;
            end
            return;
        end
        if (f.op == OP_BEGIN) begin
            start_transition();
            return;
        end
        if (f.op != OP_FRAME) return;
        act = (cc_reg > NCH) ? NCH : cc_reg;
        r.smp = f.smp;
        r.adj = 0;
        if (f.gen != seen_gen) begin
            seen_gen = f.gen;
            start_transition();
        end
        again = 1;
        while (again) begin
            again = 0;
            case (fphase)
                PH_STEADY: if (!f.avail) begin
                    start_transition();
                    again = 1;
                end
                PH_FADE_OUT: begin
                    num = (frames_left == 0) ? 0 : frames_left - 1;
                    for (int c = 0; c < act; c++) r.smp[c] = ramp(origin[c], num, fad_reg);
                    r.adj = 1;
                    if (frames_left != 0) frames_left--;
                    if (frames_left == 0) begin
                        if (pending_sil == 0) fphase = PH_AWAIT;
                        else begin
                            fphase = PH_SILENT;
                            frames_left = pending_sil;
                            pending_sil = 0;
                        end
                    end
                end
                PH_SILENT: begin
                    for (int c = 0; c < act; c++) r.smp[c] = '0;
                    r.adj = 1;
                    if (f.avail) begin
                        if (frames_left != 0) frames_left--;
                        if (frames_left == 0) fphase = PH_AWAIT;
                    end
                end
                PH_AWAIT: begin
                    if (f.avail) begin
                        if (fad_reg == 0) fphase = PH_STEADY;
                        else begin
                            fphase = PH_FADE_IN;
                            frames_left = fad_reg;
                        end
                        again = 1;
                    end else begin
                        for (int c = 0; c < act; c++) r.smp[c] = '0;
                        r.adj = 1;
                    end
                end
                PH_FADE_IN: begin
                    if (!f.avail) begin
                        start_transition();
                        again = 1;
                    end else begin
                        num = (frames_left > fad_reg) ? 0 : fad_reg - frames_left + 1;
                        for (int c = 0; c < act; c++) r.smp[c] = ramp(r.smp[c], num, fad_reg);
                        r.adj = 1;
                        if (frames_left != 0) frames_left--;
                        if (frames_left == 0) fphase = PH_STEADY;
                    end
                end
                default: begin
                    fphase = PH_STEADY;
                    again = 1;
                end
            endcase
        end
        for (int c = 0; c < act; c++) last_out[c] = r.smp[c];
        r.ph = fphase;
        expect_q.push_back(r);
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver
    int send_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                frame_t f;
                f = pending_q.pop_front();
                shape_frame(f);
                if (f.op == OP_FRAME) n_frames++; else n_ctrl++;
                send_gap = gap_len();
            end
            if (!(s_valid && !s_ready)) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_valid <= 0;
                end else if (pending_q.size() > 1 || (pending_q.size() == 1 &&
                             !(s_valid && s_ready)) ) begin
                    frame_t n;
                    n = (s_valid && s_ready) ? pending_q[0] : pending_q[0];
                    if (hold_send) s_valid <= 0;
                    else begin
                        s_valid <= 1;
                        s_op <= n.op;
                        s_available <= n.avail;
                        s_generation <= n.gen;
                        for (int c = 0; c < NCH; c++) s_in[c] <= n.smp[c];
                    end
                end else s_valid <= 0;
            end
        end
    end

    // monitor
    int recv_gap = 0;
    always @(posedge aclk) begin
        cycles++;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                shaped_t e;
                n_checked++;
                if (expect_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected output beat", $time);
                end else begin
                    e = expect_q.pop_front();
                    for (int c = 0; c < NCH; c++)
                        if (m_out[c] !== e.smp[c]) begin
                            errors++;
                            $display("%0t: sample_out_%0d expected %0d got %0d",
                                     $time, c, e.smp[c], m_out[c]);
                        end
                    if (m_adjusted !== e.adj) begin
                        errors++;
                        $display("%0t: adjusted expected %0b got %0b", $time, e.adj,
                                 m_adjusted);
                    end
                    if (m_phase_now !== e.ph) begin
                        errors++;
                        $display("%0t: phase_now expected %0d got %0d", $time, e.ph,
                                 m_phase_now);
                    end
                end
                recv_gap = gap_len();
            end
            if (recv_gap > 0) begin
                recv_gap = recv_gap - 1;
                m_ready <= 0;
            end else m_ready <= 1;
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic frame_t mk(op_t op, logic av, logic [31:0] g, int kind);
        frame_t f;
        f.op = op;
        f.avail = av;
        f.gen = g;
        for (int c = 0; c < NCH; c++)
            case (kind)
                1: f.smp[c] = 24'sh7FFFFF;
                2: f.smp[c] = 24'sh800000;
                3: f.smp[c] = '0;
                default: f.smp[c] = SB'($urandom);
            endcase
        return f;
    endfunction

    task automatic drain();
        while (pending_q.size() != 0 || s_valid || expect_q.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 0;
        case (idx)
            REG_CHANNEL_COUNT:  cc_reg = v[3:0];
            REG_SILENCE_FRAMES: sil_reg = v[15:0];
            REG_FADE_FRAMES:    fad_reg = v[15:0];
            default: seen_gen = v;
        endcase
    endtask

    logic [31:0] cur_gen;

    task automatic random_burst(int count);
        int k;
        k = 0;
        while (k < count) begin
            int p;
            p = $urandom_range(0, 99);
            if (p < 6) cur_gen = (p < 2) ? $urandom : cur_gen + 1;
            if (p >= 97) pending_q.push_back(mk(op_t'(p - 96), 1, cur_gen, 0));
            else pending_q.push_back(mk(OP_FRAME, $urandom_range(0, 9) != 0 || p < 10,
                                        cur_gen, p % 20 == 7 ? 1 : (p % 20 == 8 ? 2 : 0)));
            k++;
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        // directed: extremes, every op, generation change, underrun
        cur_gen = 0;
        write_reg(REG_FADE_FRAMES, 3);
        write_reg(REG_SILENCE_FRAMES, 2);
        pending_q.push_back(mk(OP_FRAME, 1, 0, 1));
        pending_q.push_back(mk(OP_FRAME, 1, 0, 2));
        pending_q.push_back(mk(OP_FRAME, 1, 5, 1));
        for (int i = 0; i < 4; i++) pending_q.push_back(mk(OP_FRAME, 1, 5, 2));
        pending_q.push_back(mk(OP_FRAME, 0, 5, 3));
        pending_q.push_back(mk(OP_FRAME, 1, 5, 0));
        pending_q.push_back(mk(OP_FRAME, 0, 5, 0));
        pending_q.push_back(mk(op_t'(3), 1, 5, 0));
        pending_q.push_back(mk(OP_RESET, 1, 5, 0));
        for (int i = 0; i < 4; i++) pending_q.push_back(mk(OP_FRAME, i[0], 5, 0));
        pending_q.push_back(mk(OP_BEGIN, 1, 5, 0));
        for (int i = 0; i < 6; i++) pending_q.push_back(mk(OP_FRAME, 1, 5, 1));
        drain();
        write_reg(REG_CHANNEL_COUNT, 0);
        write_reg(REG_INITIAL_GEN, 32'hFFFF_FFFF);
        cur_gen = 32'hFFFF_FFFF;
        pending_q.push_back(mk(OP_FRAME, 1, cur_gen, 0));
        pending_q.push_back(mk(OP_FRAME, 1, 0, 0));
        drain();
        // random phases across several settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_CHANNEL_COUNT, ph == 1 ? 15 : (ph == 2 ? 8 : $urandom_range(0, 9)));
            write_reg(REG_SILENCE_FRAMES, ph == 3 ? 16'hFFFF : $urandom_range(0, 4));
            write_reg(REG_FADE_FRAMES, ph == 4 ? 16'hFFFF : (ph == 5 ? 0 : $urandom_range(1, 6)));
            cur_gen = $urandom;
            write_reg(REG_INITIAL_GEN, cur_gen);
            if (ph == 3) pending_q.push_back(mk(OP_RESET, 1, cur_gen, 0));
            random_burst(ph == 3 || ph == 4 ? 60 : 220);
            if (ph == 6) begin
                while (pending_q.size() > 100) @(posedge aclk);
                hold_send = 1;
                while (expect_q.size() != 0 || s_valid) @(posedge aclk);
                hold_send = 0;
            end
            drain();
        end
        stim_done = 1;
        $display("covered %0d frames and %0d control ops, %0d output beats checked",
                 n_frames, n_ctrl, n_checked);
        $display("all phases, ops 0-3 and eight register settings exercised");
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
